// ===== design/kqnld_pkg.sv =====
// Package for the KeeLoq normal-learning decoder: widths, reset values, lane structs
// and the combinational KeeLoq round functions shared by the cells and the top level.
// Depends on nothing.
package kqnld_pkg;

    localparam int ROUNDS        = 528;
    localparam int RND_PER_CELL  = 8;
    localparam int NUM_CELLS     = (ROUNDS + RND_PER_CELL - 1) / RND_PER_CELL;
    localparam int RND_CNT_W     = $clog2(RND_PER_CELL + 1);

    localparam int WORD_W        = 32;
    localparam int KEY_W         = 64;
    localparam int SERIAL_W      = 28;
    localparam int SYNC_W        = 16;
    localparam int BUTTON_W      = 4;
    localparam int DISC_W        = 10;
    localparam int DISC_LSB      = 16;

    localparam int CFG_IDX_W     = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MANUF_KEY_HIGH = 1'b0,
        REG_MANUF_KEY_LOW  = 1'b1
    } t_cfg_reg;

    localparam logic [WORD_W-1:0] MANUF_KEY_HIGH_RST = 32'h04B7_679A;
    localparam logic [WORD_W-1:0] MANUF_KEY_LOW_RST  = 32'h954C_2F50;
    localparam logic [WORD_W-1:0] LEARN_HI_TAG       = 32'h6000_0000;
    localparam logic [WORD_W-1:0] LEARN_LO_TAG       = 32'h2000_0000;
    localparam logic [WORD_W-1:0] NLF_TABLE          = 32'h3A5C_742E;

    // One frame on its way through the key-learning cells.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] hop;
        logic [WORD_W-1:0] fixed;
        logic [WORD_W-1:0] dev_hi;
        logic [WORD_W-1:0] dev_lo;
    } t_learn_lane;

    // One frame on its way through the hopping-word decryption cells.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] data;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] fixed;
    } t_dec_lane;

    function automatic logic [KEY_W-1:0] rotl64(input logic [KEY_W-1:0] key, input int amt);
        logic [2*KEY_W-1:0] dbl;
        dbl = {key, key} << (amt % KEY_W);
        return dbl[2*KEY_W-1:KEY_W];
    endfunction

    function automatic logic [WORD_W-1:0] kq_round(input logic [WORD_W-1:0] x,
                                                   input logic kbit);
        logic [4:0] idx;
        logic       nb;
        idx = {x[30], x[25], x[19], x[8], x[0]};
        nb  = x[31] ^ x[15] ^ kbit ^ NLF_TABLE[idx];
        return {x[WORD_W-2:0], nb};
    endfunction

    // Runs up to RND_PER_CELL rounds. The key is aligned so that its first round
    // uses bit 15 and each later round the next lower bit, wrapping at 64.
    function automatic logic [WORD_W-1:0] kq_rounds(input logic [WORD_W-1:0]    x,
                                                    input logic [KEY_W-1:0]     key,
                                                    input logic [RND_CNT_W-1:0] n_rounds);
        logic [WORD_W-1:0] v;
        logic [5:0]        kidx;
        v = x;
        for (int j = 0; j < RND_PER_CELL; j++) begin
            kidx = 6'(15 - j);
            if (RND_CNT_W'(j) < n_rounds) begin
                v = kq_round(v, key[kidx]);
            end
        end
        return v;
    endfunction

endpackage

// ===== design/kqnld_learn_cell.sv =====
// One cell of the key-learning chain: runs a few rounds on both learning words at once.
// Depends on kqnld_pkg.
module kqnld_learn_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [kqnld_pkg::KEY_W-1:0]         i_key,
    input  logic [kqnld_pkg::RND_CNT_W-1:0]     i_n_rounds,
    input  kqnld_pkg::t_learn_lane              i_lane,
    output kqnld_pkg::t_learn_lane              o_lane
);

    kqnld_pkg::t_learn_lane r_lane;
    kqnld_pkg::t_learn_lane n_lane;

    always_comb begin
        n_lane        = i_lane;
        n_lane.dev_hi = kqnld_pkg::kq_rounds(i_lane.dev_hi, i_key, i_n_rounds);
        n_lane.dev_lo = kqnld_pkg::kq_rounds(i_lane.dev_lo, i_key, i_n_rounds);
    end

    // Only the valid bit is reset; the payload simply follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= n_lane.valid;
        end
        r_lane.hop    <= n_lane.hop;
        r_lane.fixed  <= n_lane.fixed;
        r_lane.dev_hi <= n_lane.dev_hi;
        r_lane.dev_lo <= n_lane.dev_lo;
    end

    assign o_lane = r_lane;

endmodule

// ===== design/kqnld_decrypt_cell.sv =====
// One cell of the hopping-word decryption chain: runs a few rounds and rotates the key.
// Depends on kqnld_pkg.
module kqnld_decrypt_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [kqnld_pkg::RND_CNT_W-1:0]     i_n_rounds,
    input  kqnld_pkg::t_dec_lane                i_lane,
    output kqnld_pkg::t_dec_lane                o_lane
);

    kqnld_pkg::t_dec_lane r_lane;
    kqnld_pkg::t_dec_lane n_lane;

    // The key leaves realigned so that the next cell again starts at bit 15.
    always_comb begin
        n_lane      = i_lane;
        n_lane.data = kqnld_pkg::kq_rounds(i_lane.data, i_lane.key, i_n_rounds);
        n_lane.key  = kqnld_pkg::rotl64(i_lane.key, kqnld_pkg::RND_PER_CELL);
    end

    // Only the valid bit is reset; the payload simply follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= n_lane.valid;
        end
        r_lane.data  <= n_lane.data;
        r_lane.key   <= n_lane.key;
        r_lane.fixed <= n_lane.fixed;
    end

    assign o_lane = r_lane;

endmodule

// ===== design/keeloq_normal_learn_decoder_top.sv =====
// Top level of the KeeLoq normal-learning decoder: configuration registers, the two
// chains of round cells and the result register. Depends on kqnld_pkg,
// kqnld_learn_cell and kqnld_decrypt_cell.
//
// Usage: a request (hopping cipher word and fixed word) is taken at every rising edge
// where start is high; busy stays low, so a new request may follow every cycle.
// The serial number is the low 28 bits of the fixed word. The device key is learned
// from it under the manufacturer key, and that key then decrypts the hopping word.
// Each result is shown for exactly one cycle with o_done high; the receiver cannot
// hold it off, so nothing ever stalls inside the block.
// It has 66 key-learning cells and 66 decryption cells, each doing eight of the 528
// cipher rounds, plus one result register. Throughput is one request per cycle, set
// by the chain of cells in which every cell is a pipeline stage. The user must write
// the manufacturer key through i_cfg_we / i_cfg_idx / i_cfg_wdata only while no
// request is in flight; the block does not enforce it. Reset clears every valid bit
// in the chains and restores the default manufacturer key, dropping requests in flight.
module keeloq_normal_learn_decoder_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [kqnld_pkg::WORD_W-1:0]           i_hop_cipher,
    input  logic [kqnld_pkg::WORD_W-1:0]           i_fixed_word,
    input  logic                                   i_cfg_we,
    input  logic [kqnld_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [kqnld_pkg::WORD_W-1:0]           i_cfg_wdata,
    output logic                                   o_done,
    output logic [kqnld_pkg::WORD_W-1:0]           o_plain_word,
    output logic [kqnld_pkg::SYNC_W-1:0]           o_sync_count,
    output logic [kqnld_pkg::BUTTON_W-1:0]         o_button_code,
    output logic [kqnld_pkg::SERIAL_W-1:0]         o_serial_id,
    output logic                                   o_check_ok
);

    localparam int NC = kqnld_pkg::NUM_CELLS;

    // Manufacturer key; the user must write it only while the block is idle, which the block does not enforce.
    logic [kqnld_pkg::WORD_W-1:0] r_manuf_key_high;
    logic [kqnld_pkg::WORD_W-1:0] r_manuf_key_low;
    logic [kqnld_pkg::KEY_W-1:0]  w_manuf_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf_key_high <= kqnld_pkg::MANUF_KEY_HIGH_RST;
            r_manuf_key_low  <= kqnld_pkg::MANUF_KEY_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (kqnld_pkg::t_cfg_reg'(i_cfg_idx))
                kqnld_pkg::REG_MANUF_KEY_HIGH: r_manuf_key_high <= i_cfg_wdata;
                kqnld_pkg::REG_MANUF_KEY_LOW:  r_manuf_key_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_manuf_key = {r_manuf_key_high, r_manuf_key_low};

    // The chains never stall, so a request is always welcome.
    assign busy = 1'b0;

    kqnld_pkg::t_learn_lane w_learn [0:NC];
    kqnld_pkg::t_dec_lane   w_dec   [0:NC];

    // Entry of the learning chain: both learning words are built from the serial.
    always_comb begin
        w_learn[0].valid  = start & ~busy;
        w_learn[0].hop    = i_hop_cipher;
        w_learn[0].fixed  = i_fixed_word;
        w_learn[0].dev_hi = kqnld_pkg::LEARN_HI_TAG
                          | {{(kqnld_pkg::WORD_W - kqnld_pkg::SERIAL_W){1'b0}},
                             i_fixed_word[kqnld_pkg::SERIAL_W-1:0]};
        w_learn[0].dev_lo = kqnld_pkg::LEARN_LO_TAG
                          | {{(kqnld_pkg::WORD_W - kqnld_pkg::SERIAL_W){1'b0}},
                             i_fixed_word[kqnld_pkg::SERIAL_W-1:0]};
    end

    // The manufacturer key is static, so every learning cell gets a copy that is
    // pre-rotated to its first round instead of carrying the key along the chain.
    for (genvar k = 0; k < NC; k++) begin : g_learn
        localparam int FIRST = k * kqnld_pkg::RND_PER_CELL;
        localparam int LEFT  = kqnld_pkg::ROUNDS - FIRST;
        localparam int NR    = (LEFT < kqnld_pkg::RND_PER_CELL) ? LEFT
                                                                 : kqnld_pkg::RND_PER_CELL;
        kqnld_learn_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (kqnld_pkg::rotl64(w_manuf_key, FIRST % kqnld_pkg::KEY_W)),
            .i_n_rounds (kqnld_pkg::RND_CNT_W'(NR)),
            .i_lane     (w_learn[k]),
            .o_lane     (w_learn[k+1])
        );
    end

    // The learned halves form the device key, which then travels with its frame.
    always_comb begin
        w_dec[0].valid = w_learn[NC].valid;
        w_dec[0].data  = w_learn[NC].hop;
        w_dec[0].key   = {w_learn[NC].dev_hi, w_learn[NC].dev_lo};
        w_dec[0].fixed = w_learn[NC].fixed;
    end

    for (genvar k = 0; k < NC; k++) begin : g_dec
        localparam int LEFT = kqnld_pkg::ROUNDS - k * kqnld_pkg::RND_PER_CELL;
        localparam int NR   = (LEFT < kqnld_pkg::RND_PER_CELL) ? LEFT
                                                                : kqnld_pkg::RND_PER_CELL;
        kqnld_decrypt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_n_rounds (kqnld_pkg::RND_CNT_W'(NR)),
            .i_lane     (w_dec[k]),
            .o_lane     (w_dec[k+1])
        );
    end

    // Result register: the discrimination bits must match the low serial bits and
    // the decrypted button nibble must match the one sent in the clear.
    logic                                r_done;
    logic [kqnld_pkg::WORD_W-1:0]        r_plain;
    logic [kqnld_pkg::SERIAL_W-1:0]      r_serial;
    logic                                r_check_ok;
    logic                                n_check_ok;
    logic [kqnld_pkg::WORD_W-1:0]        w_plain;
    logic [kqnld_pkg::WORD_W-1:0]        w_fixed;

    assign w_plain = w_dec[NC].data;
    assign w_fixed = w_dec[NC].fixed;

    assign n_check_ok =
        (w_plain[kqnld_pkg::DISC_LSB +: kqnld_pkg::DISC_W] == w_fixed[kqnld_pkg::DISC_W-1:0])
        && (w_plain[kqnld_pkg::WORD_W-1 -: kqnld_pkg::BUTTON_W]
            == w_fixed[kqnld_pkg::WORD_W-1 -: kqnld_pkg::BUTTON_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_dec[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plain    <= w_plain;
        r_serial   <= w_fixed[kqnld_pkg::SERIAL_W-1:0];
        r_check_ok <= n_check_ok;
    end

    assign o_done        = r_done;
    assign o_plain_word  = r_plain;
    assign o_sync_count  = r_plain[kqnld_pkg::SYNC_W-1:0];
    assign o_button_code = r_plain[kqnld_pkg::WORD_W-1 -: kqnld_pkg::BUTTON_W];
    assign o_serial_id   = r_serial;
    assign o_check_ok    = r_check_ok;

`ifndef NO_ASSERTIONS
    // An accepted request must occupy the first learning cell in the next cycle.
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_learn[1].valid)
        else $error("accepted request did not enter the learning chain");

    // A frame leaving the learning chain must enter the decryption chain.
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_learn[NC].valid |=> w_dec[1].valid)
        else $error("frame lost between learning and decryption chains");

    // A passed check implies the discrimination bits equal the low serial bits.
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_check_ok)
        |-> (o_plain_word[kqnld_pkg::DISC_LSB +: kqnld_pkg::DISC_W]
             == o_serial_id[kqnld_pkg::DISC_W-1:0]))
        else $error("check flag set with mismatching discrimination bits");

    // A result strobe must come from a valid frame at the end of the decryption chain.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_dec[NC].valid))
        else $error("result strobe without a finished frame");
`endif

endmodule

// ===== verif/tb_keeloq_normal_learn_decoder_top.sv =====
// Self-checking testbench for keeloq_normal_learn_decoder_top: directed and random
// rolling-code frames, with every result checked against a cycle-free decoder model.
// Depends on kqnld_pkg and the decoder top level.
module tb_keeloq_normal_learn_decoder_top;

    import kqnld_pkg::*;

    // Expected content of one decoded frame, one entry per accepted request.
    typedef struct packed {
        logic [WORD_W-1:0]   plain;
        logic [SYNC_W-1:0]   sync;
        logic [BUTTON_W-1:0] button;
        logic [SERIAL_W-1:0] serial;
        logic                ok;
    } t_frame_result;

    // Waited at the end: longer than the path through the cells and the result register.
    localparam int PIPE_DRAIN    = 140;
    localparam int MAX_GAP       = 16;
    localparam int PHASE_FRAMES  = 290;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [WORD_W-1:0]      i_hop_cipher;
    logic [WORD_W-1:0]      i_fixed_word;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [WORD_W-1:0]      i_cfg_wdata;
    logic                   o_done;
    logic [WORD_W-1:0]      o_plain_word;
    logic [SYNC_W-1:0]      o_sync_count;
    logic [BUTTON_W-1:0]    o_button_code;
    logic [SERIAL_W-1:0]    o_serial_id;
    logic                   o_check_ok;

    // The testbench's copy of the manufacturer key, high half in the upper 32 bits.
    logic [KEY_W-1:0]       manuf_key;
    // Decoded frames still owed by the block, oldest first.
    t_frame_result          frame_results_q[$];
    int                     mismatch_count;
    // Chance, in percent, that the sender sits idle in a given cycle.
    int                     idle_pct;

    keeloq_normal_learn_decoder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_hop_cipher  (i_hop_cipher),
        .i_fixed_word  (i_fixed_word),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_plain_word  (o_plain_word),
        .o_sync_count  (o_sync_count),
        .o_button_code (o_button_code),
        .o_serial_id   (o_serial_id),
        .o_check_ok    (o_check_ok)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Runaway guard: reports a fail and ends the simulation if the tests have not finished.
    initial begin
        #2_000_000;
        $display("keeloq_normal_learn_decoder_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------------

    // KeeLoq decryption: each round shifts left and feeds in bit 31 xor bit 15
    // xor the key bit xor the nonlinear function of bits 0, 8, 19, 25 and 30.
    // Round r uses key bit (15 - r) modulo 64.
    function automatic logic [WORD_W-1:0] kq_decrypt_word(input logic [WORD_W-1:0] data,
                                                          input logic [KEY_W-1:0]  key);
        logic [WORD_W-1:0] x;
        logic [4:0]        sel;
        logic [5:0]        kidx;
        logic              fb;
        x = data;
        for (int r = 0; r < ROUNDS; r++) begin
            kidx = 6'((15 - r) & 63);
            sel  = {x[30], x[25], x[19], x[8], x[0]};
            fb   = x[31] ^ x[15] ^ key[kidx] ^ NLF_TABLE[sel];
            x    = {x[WORD_W-2:0], fb};
        end
        return x;
    endfunction

    // Exact inverse of the decryption, run from the last round back to the first.
    // Used only to build frames that a transmitter would really send.
    function automatic logic [WORD_W-1:0] kq_encrypt_word(input logic [WORD_W-1:0] data,
                                                          input logic [KEY_W-1:0]  key);
        logic [WORD_W-1:0] x;
        logic [4:0]        sel;
        logic [5:0]        kidx;
        logic              fb;
        x = data;
        for (int r = ROUNDS - 1; r >= 0; r--) begin
            kidx = 6'((15 - r) & 63);
            sel  = {x[31], x[26], x[20], x[9], x[1]};
            fb   = x[0] ^ x[16] ^ key[kidx] ^ NLF_TABLE[sel];
            x    = {fb, x[WORD_W-1:1]};
        end
        return x;
    endfunction

    // Normal learning: both halves of the device key are decryptions of the
    // serial, marked with a learning tag, under the manufacturer key.
    function automatic logic [KEY_W-1:0] device_key(input logic [SERIAL_W-1:0] serial);
        logic [WORD_W-1:0] learn_word;
        learn_word = WORD_W'(serial);
        return {kq_decrypt_word(learn_word | LEARN_HI_TAG, manuf_key),
                kq_decrypt_word(learn_word | LEARN_LO_TAG, manuf_key)};
    endfunction

    function automatic t_frame_result decode_frame(input logic [WORD_W-1:0] hop,
                                                   input logic [WORD_W-1:0] fixed);
        t_frame_result     res;
        logic [WORD_W-1:0] plain;
        plain      = kq_decrypt_word(hop, device_key(fixed[SERIAL_W-1:0]));
        res.plain  = plain;
        res.sync   = plain[SYNC_W-1:0];
        res.button = plain[31:28];
        res.serial = fixed[SERIAL_W-1:0];
        // Discrimination bits must repeat the low serial bits, and the encrypted
        // button nibble must agree with the one sent in the clear.
        res.ok     = (plain[DISC_LSB +: DISC_W] == fixed[DISC_W-1:0])
                     && (plain[31:28] == fixed[31:28]);
        return res;
    endfunction

    // Hopping word for a given plain word, as the transmitter with this serial
    // would send it under the current manufacturer key.
    function automatic logic [WORD_W-1:0] sealed_hop(input logic [SERIAL_W-1:0] serial,
                                                     input logic [WORD_W-1:0]   plain);
        return kq_encrypt_word(plain, device_key(serial));
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Sends one request. Inputs move on the falling edge; the request is taken at
    // the first rising edge with busy low. Start stays high afterwards so that
    // back-to-back requests need no extra assignment; an idle gap lowers it.
    task automatic issue_frame(input logic [WORD_W-1:0] hop, input logic [WORD_W-1:0] fixed);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_hop_cipher <= hop;
        i_fixed_word <= fixed;
        do @(posedge i_clk); while (busy);
        frame_results_q.push_back(decode_frame(hop, fixed));
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic wait_idle();
        @(negedge i_clk) start <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Loads a new manufacturer key. Only done with the pipeline empty, since the
    // block applies the key to frames already in flight.
    task automatic load_manuf_key(input logic [WORD_W-1:0] key_hi,
                                  input logic [WORD_W-1:0] key_lo);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_MANUF_KEY_HIGH;
        i_cfg_wdata <= key_hi;
        @(negedge i_clk);
        i_cfg_idx   <= REG_MANUF_KEY_LOW;
        i_cfg_wdata <= key_lo;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        manuf_key = {key_hi, key_lo};
    endtask

    // A frame as a real transmitter builds it, optionally damaged afterwards.
    // Kinds: pure noise, wrong clear button, wrong discrimination bits, a flipped
    // bit in the hopping word, or a good frame.
    task automatic issue_random_frame();
        int                  kind;
        logic [SERIAL_W-1:0] serial;
        logic [BUTTON_W-1:0] button;
        logic [WORD_W-1:0]   plain;
        logic [WORD_W-1:0]   fixed;
        logic [WORD_W-1:0]   hop;
        kind = $urandom_range(99);
        if (kind < 10) begin
            issue_frame($urandom, $urandom);
        end else begin
            serial = SERIAL_W'($urandom);
            button = BUTTON_W'($urandom);
            plain  = {button, 2'($urandom), serial[DISC_W-1:0], 16'($urandom)};
            fixed  = {button, serial};
            if (kind < 18) begin
                fixed[31:28] = fixed[31:28] ^ 4'($urandom_range(1, 15));
            end else if (kind < 26) begin
                plain[DISC_LSB + $urandom_range(DISC_W - 1)] ^= 1'b1;
            end
            hop = sealed_hop(serial, plain);
            if (kind >= 26 && kind < 32) begin
                hop[$urandom_range(WORD_W - 1)] ^= 1'b1;
            end
            issue_frame(hop, fixed);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_v,
                                 input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Every strobed result must match the oldest owed frame.
    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (frame_results_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got plain %h serial %h",
                         $time, o_plain_word, o_serial_id);
                mismatch_count++;
            end else begin
                exp_r = frame_results_q.pop_front();
                compare_field("plain_word", exp_r.plain, o_plain_word);
                compare_field("sync_count", WORD_W'(exp_r.sync), WORD_W'(o_sync_count));
                compare_field("button_code", WORD_W'(exp_r.button), WORD_W'(o_button_code));
                compare_field("serial_id", WORD_W'(exp_r.serial), WORD_W'(o_serial_id));
                compare_field("check_ok", WORD_W'(exp_r.ok), WORD_W'(o_check_ok));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic apply_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    endtask

    // Default manufacturer key: field extremes, good frames and a frame with a wrong
    // button sent in the clear.
    task automatic test_default_key();
        idle_pct = 0;
        issue_frame(32'h0000_0000, 32'h0000_0000);
        issue_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_frame(32'h0000_0000, 32'hFFFF_FFFF);
        issue_frame(32'hFFFF_FFFF, 32'h0000_0000);
        issue_frame(sealed_hop(28'h000_0000, 32'h0000_0000), 32'h0000_0000);
        issue_frame(sealed_hop(28'hFFF_FFFF, 32'hFFFF_FFFF), 32'hFFFF_FFFF);
        issue_frame(sealed_hop(28'h123_4567, 32'h5167_0000), 32'h3123_4567);
        issue_frame(sealed_hop(28'h0AB_CDEF, 32'h91EF_8001), 32'h90AB_CDEF);
    endtask

    // All-zero and all-one manufacturer keys.
    task automatic test_key_extremes();
        logic [WORD_W-1:0] fill;
        for (int k = 0; k < 2; k++) begin
            fill = (k == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            load_manuf_key(fill, fill);
            issue_frame(sealed_hop(28'h000_0000, 32'h0000_FFFF), 32'h0000_0000);
            issue_frame(sealed_hop(28'hFFF_FFFF, 32'hF3FF_0000), 32'hFFFF_FFFF);
            issue_frame(sealed_hop(28'h8000_3FF, 32'h73FF_1234), 32'h6800_03FF);
            issue_frame(32'hA5A5_A5A5, 32'h5A5A_5A5A);
            issue_frame(32'hFFFF_FFFF, 32'h0000_0000);
        end
    endtask

    // Random frames under a fresh random key in each phase, with the sender
    // running flat out, idling heavily, idling lightly, and flat out again.
    // Now and then the sender also waits for the pipeline to run dry.
    task automatic test_random_traffic();
        int phase_idle[4];
        phase_idle = '{0, 60, 27, 0};
        for (int p = 0; p < 4; p++) begin
            load_manuf_key($urandom, $urandom);
            idle_pct = phase_idle[p];
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                issue_random_frame();
                if ($urandom_range(199) == 0) wait_idle();
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_hop_cipher   <= '0;
        i_fixed_word   <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_MANUF_KEY_HIGH;
        i_cfg_wdata    <= '0;
        manuf_key      = {MANUF_KEY_HIGH_RST, MANUF_KEY_LOW_RST};
        mismatch_count = 0;
        idle_pct       = 0;

        apply_reset();
        test_default_key();
        test_key_extremes();
        test_random_traffic();

        // Drain, then give the pipeline time to show any stray result.
        wait_idle();
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("keeloq_normal_learn_decoder_top regression: pass");
        end else begin
            $display("keeloq_normal_learn_decoder_top regression: fail");
        end
        $finish;
    end

endmodule
